[rtl/indexed_list_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// indexed list engine assertion macros
// concurrent assertion shorthands sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_UNIT_MACROS_SVH
`define INDEXED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define ILE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list engine check failed");

// next-cycle implication
`define ILE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list engine check failed");

`endif

[rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// indexed list engine package
// sizes, codes and control/status bundles shared by the list engine modules
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// fixed field widths
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int FPOS_W   = 6;
	localparam int TOTAL_W  = 7;

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// stream packing
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int POS_LSB   = 0;
	localparam int WORD_LSB  = POS_W;
	localparam int M_PAD_W   = M_TDATA_W - WORD_W - FPOS_W - TOTAL_W;

	typedef enum logic [CMD_W-1:0] {
		OP_APPEND = 3'd0,
		OP_DROP   = 3'd1,
		OP_READ   = 3'd2,
		OP_FIND   = 3'd3,
		OP_INSERT = 3'd4,
		OP_ERASE  = 3'd5,
		OP_CLEAR  = 3'd6
	} ile_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} ile_status_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_AT_COUNT,
		WR_AT_POS,
		WR_UP,
		WR_DOWN
	} ile_wr_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_DEC,
		PTR_ZERO,
		PTR_POS,
		PTR_LAST,
		PTR_POS_P1
	} ile_ptr_t;

	typedef struct packed {
		logic        load;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        cnt_clr;
		ile_ptr_t    ptr_op;
		logic        rd_issue;
		ile_wr_t     wr_sel;
		logic        set_status;
		ile_status_t status;
		logic        cap_read;
		logic        cap_find;
		logic        emit;
	} ile_ctl_t;

	typedef struct packed {
		ile_op_t op;
		logic    full;
		logic    empty;
		logic    pos_gt_cnt;
		logic    pos_ge_cnt;
		logic    pos_eq_cnt;
		logic    pos_p1_eq_cnt;
		logic    ptr_eq_pos;
		logic    ptr_eq_last;
		logic    pend;
		logic    match;
		logic    out_free;
	} ile_sts_t;

endpackage

[rtl/ile_ram.sv]
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/ile_ctrl.sv]
// ----------------------------------------------------------------------------
// indexed list engine controller
// sequences decode, memory walk, tail write and result hand-off
// ----------------------------------------------------------------------------
module ile_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ile_pkg::ile_sts_t sts,
	output ile_pkg::ile_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_TAIL,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   last_now;
	logic   ready_q;

	// insert and read stop at the position, find and erase at the last element
	assign last_now = (sts.op == ile_pkg::OP_INSERT || sts.op == ile_pkg::OP_READ) ?
		sts.ptr_eq_pos : sts.ptr_eq_last;

	assign s_tready = ready_q;

	always_comb begin
		ctl        = '0;
		ctl.ptr_op = ile_pkg::PTR_HOLD;
		ctl.wr_sel = ile_pkg::WR_NONE;
		ctl.status = ile_pkg::ST_OK;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && ready_q) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					ile_pkg::OP_APPEND: begin
						if (sts.full) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_FULL;
						end else begin
							ctl.wr_sel  = ile_pkg::WR_AT_COUNT;
							ctl.cnt_inc = 1'b1;
						end
					end
					ile_pkg::OP_DROP: begin
						ctl.cnt_dec = !sts.empty;
					end
					ile_pkg::OP_READ: begin
						if (sts.pos_ge_cnt) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_RANGE;
						end else begin
							ctl.ptr_op = ile_pkg::PTR_POS;
						end
					end
					ile_pkg::OP_FIND: begin
						if (sts.empty) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_MISSING;
						end else begin
							ctl.ptr_op = ile_pkg::PTR_ZERO;
						end
					end
					ile_pkg::OP_INSERT: begin
						if (sts.pos_gt_cnt) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_RANGE;
						end else if (sts.full) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_FULL;
						end else if (sts.pos_eq_cnt) begin
							ctl.wr_sel  = ile_pkg::WR_AT_POS;
							ctl.cnt_inc = 1'b1;
						end else begin
							ctl.ptr_op = ile_pkg::PTR_LAST;
						end
					end
					ile_pkg::OP_ERASE: begin
						if (sts.pos_ge_cnt) begin
							ctl.set_status = 1'b1;
							ctl.status     = ile_pkg::ST_RANGE;
						end else if (sts.pos_p1_eq_cnt) begin
							ctl.cnt_dec = 1'b1;
						end else begin
							ctl.ptr_op = ile_pkg::PTR_POS_P1;
						end
					end
					ile_pkg::OP_CLEAR: begin
						ctl.cnt_clr = 1'b1;
					end
					default: begin
					end
				endcase
				state_d = (ctl.ptr_op != ile_pkg::PTR_HOLD) ? S_WALK : S_DONE;
			end
			S_WALK: begin
				if (!last_q) begin
					ctl.rd_issue = 1'b1;
					ctl.ptr_op   = (sts.op == ile_pkg::OP_INSERT) ?
						ile_pkg::PTR_DEC : ile_pkg::PTR_INC;
				end
				if (sts.pend) begin
					unique case (sts.op)
						ile_pkg::OP_FIND: begin
							if (sts.match) begin
								ctl.cap_find = 1'b1;
								state_d      = S_DONE;
							end else if (last_q) begin
								ctl.set_status = 1'b1;
								ctl.status     = ile_pkg::ST_MISSING;
								state_d        = S_DONE;
							end
						end
						ile_pkg::OP_READ: begin
							ctl.cap_read = 1'b1;
							state_d      = S_DONE;
						end
						ile_pkg::OP_INSERT: begin
							ctl.wr_sel = ile_pkg::WR_UP;
							if (last_q) begin
								state_d = S_TAIL;
							end
						end
						ile_pkg::OP_ERASE: begin
							ctl.wr_sel = ile_pkg::WR_DOWN;
							if (last_q) begin
								ctl.cnt_dec = 1'b1;
								state_d     = S_DONE;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_TAIL: begin
				ctl.wr_sel  = ile_pkg::WR_AT_POS;
				ctl.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
			if (state_d == S_WALK && state_q == S_WALK) begin
				last_q <= last_q | last_now;
			end else begin
				last_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/ile_dp.sv]
// ----------------------------------------------------------------------------
// indexed list engine datapath
// item registers, element count, walk pointer, element ram and output register
// ----------------------------------------------------------------------------
module ile_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [ile_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [ile_pkg::STATUS_W-1:0]    m_tuser,
	input  ile_pkg::ile_ctl_t               ctl,
	output ile_pkg::ile_sts_t               sts
);

	logic [ile_pkg::CMD_W-1:0]   cmd_q;
	logic [ile_pkg::POS_W-1:0]   pos_q;
	logic [ile_pkg::WORD_W-1:0]  word_q;
	logic [ile_pkg::CNT_W-1:0]   count_q;
	logic [ile_pkg::CNT_W-1:0]   ptr_q;
	logic                        pend_s1;
	logic [ile_pkg::ADDR_W-1:0]  pend_addr_s1;
	ile_pkg::ile_status_t        status_q;
	logic [ile_pkg::WORD_W-1:0]  rd_q;
	logic [ile_pkg::FPOS_W-1:0]  fpos_q;
	logic                        m_tvalid_q;
	logic [ile_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [ile_pkg::STATUS_W-1:0]  m_tuser_q;

	logic [ile_pkg::CMP_W-1:0]   pos_ext;
	logic [ile_pkg::CMP_W-1:0]   cnt_ext;
	logic [ile_pkg::CMP_W-1:0]   ptr_ext;
	logic                        ram_we;
	logic [ile_pkg::ADDR_W-1:0]  ram_waddr;
	logic [ile_pkg::WORD_W-1:0]  ram_wdata;
	logic [ile_pkg::WORD_W-1:0]  ram_rdata;

	assign pos_ext = ile_pkg::CMP_W'(pos_q);
	assign cnt_ext = ile_pkg::CMP_W'(count_q);
	assign ptr_ext = ile_pkg::CMP_W'(ptr_q);

	always_comb begin
		sts               = '0;
		sts.op            = ile_pkg::ile_op_t'(cmd_q);
		sts.full          = (count_q == ile_pkg::CNT_W'(ile_pkg::DEPTH));
		sts.empty         = (count_q == '0);
		sts.pos_gt_cnt    = (pos_ext > cnt_ext);
		sts.pos_ge_cnt    = (pos_ext >= cnt_ext);
		sts.pos_eq_cnt    = (pos_ext == cnt_ext);
		sts.pos_p1_eq_cnt = ((pos_ext + 1'b1) == cnt_ext);
		sts.ptr_eq_pos    = (ptr_ext == pos_ext);
		sts.ptr_eq_last   = (ptr_q == (count_q - 1'b1));
		sts.pend          = pend_s1;
		sts.match         = pend_s1 && (ram_rdata == word_q);
		sts.out_free      = !m_tvalid_q || m_tready;
	end

	// write port: new word at count or position, or a shifted element one slot over
	always_comb begin
		ram_we    = (ctl.wr_sel != ile_pkg::WR_NONE);
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		unique case (ctl.wr_sel)
			ile_pkg::WR_NONE: begin
			end
			ile_pkg::WR_AT_COUNT: begin
				ram_waddr = count_q[ile_pkg::ADDR_W-1:0];
				ram_wdata = word_q;
			end
			ile_pkg::WR_AT_POS: begin
				ram_waddr = ile_pkg::ADDR_W'(pos_q);
				ram_wdata = word_q;
			end
			ile_pkg::WR_UP: begin
				ram_waddr = pend_addr_s1 + 1'b1;
			end
			ile_pkg::WR_DOWN: begin
				ram_waddr = pend_addr_s1 - 1'b1;
			end
			default: begin
			end
		endcase
	end

	ile_ram #(
		.WIDTH (ile_pkg::WORD_W),
		.DEPTH (ile_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.rd_issue),
		.raddr (ptr_q[ile_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// item and walk registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= s_tuser;
			pos_q  <= s_tdata[ile_pkg::POS_LSB +: ile_pkg::POS_W];
			word_q <= s_tdata[ile_pkg::WORD_LSB +: ile_pkg::WORD_W];
		end
		unique case (ctl.ptr_op)
			ile_pkg::PTR_HOLD:   ptr_q <= ptr_q;
			ile_pkg::PTR_INC:    ptr_q <= ptr_q + 1'b1;
			ile_pkg::PTR_DEC:    ptr_q <= ptr_q - 1'b1;
			ile_pkg::PTR_ZERO:   ptr_q <= '0;
			ile_pkg::PTR_POS:    ptr_q <= ile_pkg::CNT_W'(pos_q);
			ile_pkg::PTR_LAST:   ptr_q <= count_q - 1'b1;
			ile_pkg::PTR_POS_P1: ptr_q <= ile_pkg::CNT_W'(pos_q) + 1'b1;
			default:             ptr_q <= ptr_q;
		endcase
		pend_addr_s1 <= ptr_q[ile_pkg::ADDR_W-1:0];
		if (ctl.load) begin
			status_q <= ile_pkg::ST_OK;
			rd_q     <= '0;
			fpos_q   <= '0;
		end else begin
			if (ctl.set_status) begin
				status_q <= ctl.status;
			end
			if (ctl.cap_read) begin
				rd_q <= ram_rdata;
			end
			if (ctl.cap_find) begin
				fpos_q <= ile_pkg::FPOS_W'(pend_addr_s1);
			end
		end
		if (ctl.emit) begin
			m_tdata_q <= {{ile_pkg::M_PAD_W{1'b0}}, ile_pkg::TOTAL_W'(count_q), fpos_q, rd_q};
			m_tuser_q <= status_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pend_s1 <= ctl.rd_issue;
			if (ctl.cnt_clr) begin
				count_q <= '0;
			end else if (ctl.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (ctl.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[rtl/indexed_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// indexed list engine unit
// fixed-capacity ordered list of signed 32-bit words with append, drop, read,
// find, insert, erase and clear; one result transfer per command transfer
// ----------------------------------------------------------------------------
//
// channel | direction | tdata (low bit up)                        | tuser
// --------+-----------+-------------------------------------------+--------
// s_*     | in        | position[6:0], word[38:7], pad            | command
// m_*     | out       | read_word[31:0], found_position[37:32],   | status
//         |           | element_total[44:38], pad                 |
//
// append, drop, clear, the unused code, rejected commands, insert at the end and
// erase of the last element finish at decode; read, find, other erases and other
// inserts walk the stored words, an insert then writing its new word; a walk reads
// one stored word a cycle and writes the shifted word in the following cycle
// reset: element count goes to zero, ready low; stored words undefined until written
// stalls: a held result sits in the output register; the next command's result waits
//
module indexed_list_engine_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ile_pkg::S_TDATA_W-1:0]   s_tdata,   // position[6:0], word[38:7]
	input  logic [ile_pkg::CMD_W-1:0]       s_tuser,   // command[2:0]
	// result side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ile_pkg::M_TDATA_W-1:0]   m_tdata,   // read_word[31:0],
	                                                   // found_position[37:32],
	                                                   // element_total[44:38]
	output logic [ile_pkg::STATUS_W-1:0]    m_tuser    // status[1:0]
);

	// command bundle from the controller, flags back from the datapath
	ile_pkg::ile_ctl_t ctl;
	ile_pkg::ile_sts_t sts;

	// state machine: decode, memory walk, tail write, result hand-off
	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// element store, count, walk pointer and output register
	ile_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule

[rtl/ile_chk.sv]
// ----------------------------------------------------------------------------
// indexed list engine checker
// port-level checks on result fields and transfer sequencing
// ----------------------------------------------------------------------------
`include "indexed_list_engine_unit_macros.svh"

module ile_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ile_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [ile_pkg::STATUS_W-1:0]    m_tuser
);

	// a full status only when the list holds every slot
	`ILE_ASSERT_IMP(a_full_total, m_tvalid && (m_tuser == ile_pkg::ST_FULL), m_tdata[44:38] == ile_pkg::TOTAL_W'(ile_pkg::DEPTH))

	// failed commands carry no read word and no found position
	`ILE_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tuser != ile_pkg::ST_OK), (m_tdata[31:0] == '0) && (m_tdata[37:32] == '0))

	// a found position lies inside the list
	`ILE_ASSERT_IMP(a_found_inside, m_tvalid && (m_tdata[37:32] != '0), m_tdata[44:38] > ile_pkg::TOTAL_W'(m_tdata[37:32]))

	// one command at a time: ready drops after a command transfer
	`ILE_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

	// a stalled result holds
	`ILE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind indexed_list_engine_unit ile_chk u_ile_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// indexed list engine unit testbench
// drives list commands over the command stream and checks every result
// against a list model kept in a small scoreboard class. a directed opening
// hits empty, edge and rejected cases, then random phases grow the list
// until it is full, shrink it and mix all commands. both stream sides idle
// at random, and a long output stall backs up the command side.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	// command code seven has no operation behind it
	localparam logic [CMD_W-1:0] OP_RESERVED = 3'd7;

	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 100;

	typedef enum int {
		PHASE_GROW,
		PHASE_SHRINK,
		PHASE_MIXED
	} phase_kind_t;

	// list model plus the results it still waits for
	class list_scoreboard;

		typedef struct {
			logic [STATUS_W-1:0]      status;
			logic signed [WORD_W-1:0] read_word;
			logic [FPOS_W-1:0]        found_position;
			logic [TOTAL_W-1:0]       element_total;
		} list_result_t;

		logic signed [WORD_W-1:0] words [DEPTH];
		int                       count;
		list_result_t             awaited [$];
		int                       errors;
		int                       compared;
		int                       deepest;
		int                       status_seen [4];

		function logic signed [WORD_W-1:0] peek(int idx);
			return words[idx];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// work out the result of one accepted command and update the list
		task note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
				logic signed [WORD_W-1:0] word);
			list_result_t r;
			int           p;
			r.status         = ST_OK;
			r.read_word      = '0;
			r.found_position = '0;
			p                = int'(pos);
			case (cmd)
				OP_APPEND: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						words[count] = word;
						count++;
					end
				end
				OP_DROP: begin
					if (count > 0) count--;
				end
				OP_READ: begin
					if (p >= count) r.status = ST_RANGE;
					else r.read_word = words[p];
				end
				OP_FIND: begin
					r.status = ST_MISSING;
					for (int i = 0; i < count; i++) begin
						if (words[i] == word) begin
							r.status         = ST_OK;
							r.found_position = FPOS_W'(i);
							break;
						end
					end
				end
				OP_INSERT: begin
					if (p > count) begin
						r.status = ST_RANGE;
					end else if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (int i = count; i > p; i--) words[i] = words[i-1];
						words[p] = word;
						count++;
					end
				end
				OP_ERASE: begin
					if (p >= count) begin
						r.status = ST_RANGE;
					end else begin
						for (int i = p; i + 1 < count; i++) words[i] = words[i+1];
						count--;
					end
				end
				OP_CLEAR: begin
					count = 0;
				end
				default: begin
				end
			endcase
			r.element_total = TOTAL_W'(count);
			if (count > deepest) deepest = count;
			status_seen[r.status]++;
			awaited.push_back(r);
		endtask

		task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			$display("[%0t] result %0d: %s is %h, expected %h", $time, compared, what,
				got, want);
			errors++;
		endtask

		// compare one result transfer with the oldest awaited result
		task check_result(logic [STATUS_W-1:0] status, logic signed [WORD_W-1:0] rd,
				logic [FPOS_W-1:0] fpos, logic [TOTAL_W-1:0] total);
			list_result_t want;
			if (awaited.size() == 0) begin
				report("result with no command outstanding, status", status, '0);
				return;
			end
			want = awaited.pop_front();
			compared++;
			if (status !== want.status) report("status", status, want.status);
			if (rd !== want.read_word) report("read_word", rd, want.read_word);
			if (fpos !== want.found_position)
				report("found_position", fpos, want.found_position);
			if (total !== want.element_total)
				report("element_total", total, want.element_total);
		endtask

	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	list_scoreboard sb;
	int             sent;
	int             directed_count;
	bit             src_fast;
	bit             sink_fast;
	int             sink_hold;

	indexed_list_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one command after a random gap and hold it until the transfer
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] word);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(S_TDATA_W - WORD_W - POS_W){1'b0}}, word, pos};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, pos, word);
		sent++;
	endtask

	// stop offering and wait for every awaited result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// pick a random command shaped by the phase and the current list length
	task automatic pick_command(input phase_kind_t kind, output logic [CMD_W-1:0] cmd,
			output logic [POS_W-1:0] pos, output logic [WORD_W-1:0] word);
		int r;
		int cnt;
		int sel;
		r   = $urandom_range(0, 99);
		cnt = sb.count;
		case (kind)
			PHASE_GROW: begin
				if (r < 45) cmd = OP_APPEND;
				else if (r < 75) cmd = OP_INSERT;
				else if (r < 85) cmd = OP_FIND;
				else if (r < 95) cmd = OP_READ;
				else cmd = OP_ERASE;
			end
			PHASE_SHRINK: begin
				if (r < 35) cmd = OP_ERASE;
				else if (r < 55) cmd = OP_DROP;
				else if (r < 70) cmd = OP_READ;
				else if (r < 85) cmd = OP_FIND;
				else if (r < 95) cmd = OP_APPEND;
				else if (r < 98) cmd = OP_INSERT;
				else cmd = OP_CLEAR;
			end
			default: begin
				if (r < 16) cmd = OP_APPEND;
				else if (r < 28) cmd = OP_DROP;
				else if (r < 44) cmd = OP_READ;
				else if (r < 60) cmd = OP_FIND;
				else if (r < 76) cmd = OP_INSERT;
				else if (r < 92) cmd = OP_ERASE;
				else if (r < 96) cmd = OP_CLEAR;
				else cmd = OP_RESERVED;
			end
		endcase
		// mostly in range, sometimes at or just past the end, sometimes anywhere
		sel = $urandom_range(0, 9);
		if (sel <= 6) pos = POS_W'($urandom_range(0, cnt));
		else if (sel == 7) pos = POS_W'(cnt);
		else if (sel == 8) pos = POS_W'(cnt + 1);
		else pos = POS_W'($urandom_range(0, 127));
		// a small pool makes duplicates, stored words make find hits
		sel = $urandom_range(0, 9);
		if (sel <= 3) word = WORD_W'($signed($urandom_range(0, 15)) - 8);
		else if (sel <= 5 && cnt > 0) word = sb.peek($urandom_range(0, cnt - 1));
		else if (sel == 6) begin
			case ($urandom_range(0, 3))
				0: word = 32'h8000_0000;
				1: word = 32'h7fff_ffff;
				2: word = 32'hffff_ffff;
				default: word = 32'h0000_0000;
			endcase
		end else word = $urandom();
	endtask

	// result side: random stall before each transfer, or the long hold-off
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) stall = sink_hold;
			else stall = sink_fast ? 0 : $urandom_range(0, 11);
			sink_hold = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tuser, m_tdata[WORD_W-1:0],
				m_tdata[WORD_W+FPOS_W-1:WORD_W],
				m_tdata[WORD_W+FPOS_W+TOTAL_W-1:WORD_W+FPOS_W]);
		end
	end

	// command side and run control
	initial begin
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		phase_kind_t       kind;
		int                phase_no;
		int                phase_len;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty list, field extremes, edges and rejections
		send_command(OP_CLEAR,    7'd0,   32'h0000_0000);  // clear when empty
		send_command(OP_DROP,     7'd0,   32'h0000_0000);  // drop on empty list
		send_command(OP_READ,     7'd0,   32'h0000_0000);  // read on empty list
		send_command(OP_ERASE,    7'd0,   32'h0000_0000);  // erase on empty list
		send_command(OP_FIND,     7'd0,   32'h0000_0000);  // find in empty list
		send_command(OP_INSERT,   7'd1,   32'h1111_1111);  // insert past the end
		send_command(OP_INSERT,   7'd0,   32'h8000_0000);  // insert into empty
		send_command(OP_APPEND,   7'd0,   32'h7fff_ffff);
		send_command(OP_APPEND,   7'd0,   32'hffff_ffff);
		send_command(OP_APPEND,   7'd0,   32'h0000_0000);
		send_command(OP_INSERT,   7'd4,   32'h5a5a_5a5a);  // insert at the end
		send_command(OP_INSERT,   7'd2,   32'h1234_5678);  // insert in the middle
		send_command(OP_READ,     7'd0,   32'h0000_0000);
		send_command(OP_READ,     7'd5,   32'h0000_0000);  // last element
		send_command(OP_READ,     7'd6,   32'h0000_0000);  // read at the count
		send_command(OP_READ,     7'd127, 32'hffff_ffff);  // widest position
		send_command(OP_FIND,     7'd0,   32'hffff_ffff);  // hit
		send_command(OP_FIND,     7'd0,   32'h0bad_f00d);  // no match
		send_command(OP_ERASE,    7'd5,   32'h0000_0000);  // erase the last one
		send_command(OP_ERASE,    7'd0,   32'h0000_0000);  // erase the first one
		send_command(OP_ERASE,    7'd127, 32'h0000_0000);  // erase out of range
		send_command(OP_RESERVED, 7'd127, 32'hffff_ffff);  // unused code is ignored
		send_command(OP_DROP,     7'd0,   32'h0000_0000);
		send_command(OP_CLEAR,    7'd0,   32'h0000_0000);  // stored words stay
		send_command(OP_APPEND,   7'd0,   32'h0000_0055);
		directed_count = sent;
		drain_results();

		// random phases; the first one fills the list up to full
		phase_no = 0;
		while (sent < directed_count + RANDOM_ITEMS) begin
			if (phase_no == 0) kind = PHASE_GROW;
			else kind = phase_kind_t'($urandom_range(0, 2));
			phase_len = (kind == PHASE_GROW) ? $urandom_range(100, 140)
				: $urandom_range(30, 80);
			src_fast  = ($urandom_range(0, 3) == 0);
			sink_fast = ($urandom_range(0, 3) == 0);
			// long output stall while commands keep coming
			if (phase_no == 2) sink_hold = HOLD_CYCLES;
			repeat (phase_len) begin
				pick_command(kind, cmd, pos, word);
				send_command(cmd, pos, word);
			end
			// pause the command side until everything has come back
			if (phase_no % 4 == 3) drain_results();
			phase_no++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d commands (%0d directed), compared %0d results, list reached %0d of %0d",
			sent, directed_count, sb.compared, sb.deepest, DEPTH);
		$display("statuses seen: %0d ok, %0d out of range, %0d full, %0d not found",
			sb.status_seen[ST_OK], sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL],
			sb.status_seen[ST_MISSING]);
		if (sb.errors == 0) begin
			$display("** indexed_list_engine_unit: PASSED **");
		end else begin
			$display("** indexed_list_engine_unit: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("** indexed_list_engine_unit: FAILED **");
		$finish;
	end

endmodule
